FILE: rtl/qam16_decision_directed_pll_unit_defines.svh
// assertion macros shared by the checker of the decision-directed pll
// no dependencies; included by the checker file
`ifndef QAM16_DECISION_DIRECTED_PLL_UNIT_DEFINES_SVH
`define QAM16_DECISION_DIRECTED_PLL_UNIT_DEFINES_SVH

// antecedent in this cycle implies consequent in the next
`define QDDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qddp assertion failed");

// antecedent implies consequent in the same cycle
`define QDDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qddp assertion failed");

`endif

FILE: rtl/qddp_pkg.sv
// shared types and constants of the decision-directed pll
// no dependencies
package qddp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam logic [16:0] ONE_OVER_K = 17'd39797;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_COEFF = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VCO_COEFF   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       rot_step;
        logic       vec_step;
        logic [3:0] step_idx;
        logic       round;
        logic       load_out;
        logic       decide;
        logic       vec_init;
        logic       err_mul;
        logic       fin;
        logic       int_mul;
        logic       integ;
        logic       drive;
        logic       vco_mul;
        logic       vco_add;
    } cmd_t;

    // arctangent of 2^-i, 2^32 is one turn
    function automatic logic signed [33:0] atan_angle(input logic [3:0] idx);
        logic signed [33:0] a;
        begin
            case (idx)
                4'd0:    a = 34'sd536870912;
                4'd1:    a = 34'sd316933406;
                4'd2:    a = 34'sd167458907;
                4'd3:    a = 34'sd85004756;
                4'd4:    a = 34'sd42667331;
                4'd5:    a = 34'sd21354465;
                4'd6:    a = 34'sd10679838;
                4'd7:    a = 34'sd5340245;
                4'd8:    a = 34'sd2670163;
                4'd9:    a = 34'sd1335087;
                4'd10:   a = 34'sd667544;
                4'd11:   a = 34'sd333772;
                4'd12:   a = 34'sd166886;
                4'd13:   a = 34'sd83443;
                4'd14:   a = 34'sd41722;
                4'd15:   a = 34'sd20861;
                default: a = 34'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

FILE: rtl/qddp_ctrl.sv
// sequencing state machine of the decision-directed pll
// depends on qddp_pkg (cmd_t)
module qddp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output qddp_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROT   = 4'd1;
    localparam logic [3:0] S_ROUND = 4'd2;
    localparam logic [3:0] S_OUT   = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_VINIT = 4'd5;
    localparam logic [3:0] S_VEC   = 4'd6;
    localparam logic [3:0] S_EMUL  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_IMUL  = 4'd9;
    localparam logic [3:0] S_INTEG = 4'd10;
    localparam logic [3:0] S_DRIVE = 4'd11;
    localparam logic [3:0] S_VMUL  = 4'd12;
    localparam logic [3:0] S_VADD  = 4'd13;

    localparam logic [3:0] LAST_STEP = 4'(qddp_pkg::CORDIC_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.step_idx   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = 4'd0;
                    state_next  = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_VINIT;
            end
            S_VINIT:
            begin
                cmd.vec_init = 1'b1;
                cnt_next     = 4'd0;
                state_next   = S_VEC;
            end
            S_VEC:
            begin
                cmd.vec_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.err_mul = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IMUL;
            end
            S_IMUL:
            begin
                cmd.int_mul = 1'b1;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.integ  = 1'b1;
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                cmd.drive  = 1'b1;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd.vco_mul = 1'b1;
                state_next  = S_VADD;
            end
            S_VADD:
            begin
                cmd.vco_add = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/qddp_datapath.sv
// datapath of the decision-directed pll: shared cordic, slicer, loop filter, vco
// depends on qddp_pkg (cmd_t, atan_angle, ONE_OVER_K)
module qddp_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qddp_pkg::cmd_t                cmd,
    input  logic signed [SAMPLE_BITS-1:0] in_i,
    input  logic signed [SAMPLE_BITS-1:0] in_q,
    input  logic [31:0]                   loop_gain,
    input  logic [31:0]                   integ_coeff,
    input  logic [31:0]                   vco_coeff,
    output logic signed [SAMPLE_BITS-1:0] out_i,
    output logic signed [SAMPLE_BITS-1:0] out_q
);

    localparam int W  = SAMPLE_BITS + 20;
    localparam int PW = SAMPLE_BITS + 3;
    localparam int MW = W + 18;
    localparam int SH = 64 - PHASE_BITS;

    localparam logic signed [MW-1:0] RND = MW'(8388608);
    localparam logic signed [33:0] HALF_TURN = 34'sh0_8000_0000;
    localparam logic signed [33:0] QTR_TURN  = 34'sh0_4000_0000;
    localparam logic [2*SAMPLE_BITS+3:0] THR = (2*SAMPLE_BITS+4)'(1) << (2*SAMPLE_BITS-4);

    // cordic registers, shared by rotation and vectoring
    logic signed [W-1:0]  cx_reg, cy_reg;
    logic signed [33:0]   cz_reg;

    logic signed [SAMPLE_BITS-1:0] ox_reg, oy_reg, out_i_reg, out_q_reg;
    logic signed [2:0]    dx_reg, dy_reg;
    logic                 zero_reg;
    logic signed [48:0]   ep_reg;
    logic signed [31:0]   fin_reg, prev_err_reg;
    logic signed [32:0]   sum_reg;
    logic signed [49:0]   phi_reg, plo_reg;
    logic signed [47:0]   fi_reg, prev_drive_reg;
    logic signed [48:0]   vs_reg;
    logic [63:0]          lo_reg;
    logic [48:0]          hi_reg;
    logic                 neg_reg;
    logic [PHASE_BITS-1:0] phase_reg;

    // phase to 32-bit turn units, negated, folded to within a quarter turn
    logic [31:0]          phase32, ang;
    logic signed [33:0]   rin, r0;
    logic                 flip;
    logic signed [W-1:0]  xin, yin;

    generate
        if (PHASE_BITS >= 32)
        begin : g_ph_hi
            assign phase32 = phase_reg[PHASE_BITS-1 -: 32];
        end
        else
        begin : g_ph_lo
            assign phase32 = {phase_reg, {(32-PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign ang = 32'd0 - phase32;
    assign rin = {{2{ang[31]}}, ang};
    assign xin = {{(W-SAMPLE_BITS-8){in_i[SAMPLE_BITS-1]}}, in_i, 8'b0};
    assign yin = {{(W-SAMPLE_BITS-8){in_q[SAMPLE_BITS-1]}}, in_q, 8'b0};

    always_comb
    begin
        flip = 1'b0;
        r0   = rin;
        case (ang[31:30])
            2'b01:
            begin
                flip = 1'b1;
                r0   = rin - HALF_TURN;
            end
            2'b10:
            begin
                flip = 1'b1;
                r0   = rin + HALF_TURN;
            end
            default:
            begin
                flip = 1'b0;
                r0   = rin;
            end
        endcase
    end

    // one micro-rotation
    logic signed [W-1:0]  sx, sy;
    logic signed [33:0]   atn;
    logic                 cw;

    assign sx  = cy_reg >>> cmd.step_idx;
    assign sy  = cx_reg >>> cmd.step_idx;
    assign atn = qddp_pkg::atan_angle(cmd.step_idx);
    assign cw  = cmd.vec_step ? !cy_reg[W-1] : cz_reg[33];

    // gain correction and rounding
    logic signed [MW-1:0] mx, my, rx, ry;
    logic signed [SAMPLE_BITS-1:0] rsx, rsy;

    assign mx = cx_reg * $signed({1'b0, qddp_pkg::ONE_OVER_K});
    assign my = cy_reg * $signed({1'b0, qddp_pkg::ONE_OVER_K});
    assign rx = (mx + RND) >>> 24;
    assign ry = (my + RND) >>> 24;

    always_comb
    begin
        if (rx[MW-1:SAMPLE_BITS-1] != {(MW-SAMPLE_BITS+1){rx[MW-1]}})
            rsx = rx[MW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            rsx = rx[SAMPLE_BITS-1:0];
        if (ry[MW-1:SAMPLE_BITS-1] != {(MW-SAMPLE_BITS+1){ry[MW-1]}})
            rsy = ry[MW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            rsy = ry[SAMPLE_BITS-1:0];
    end

    // slicer, exact 2/sqrt(10) boundary
    logic [SAMPLE_BITS-1:0]     magx, magy;
    logic [2*SAMPLE_BITS+3:0]   sqx, sqy;
    logic signed [2:0]          lvx, lvy;

    assign magx = ox_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ox_reg) : ox_reg;
    assign magy = oy_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-oy_reg) : oy_reg;
    assign sqx  = (2*SAMPLE_BITS+4)'(magx) * (2*SAMPLE_BITS+4)'(magx)
                * (2*SAMPLE_BITS+4)'(10);
    assign sqy  = (2*SAMPLE_BITS+4)'(magy) * (2*SAMPLE_BITS+4)'(magy)
                * (2*SAMPLE_BITS+4)'(10);

    always_comb
    begin
        lvx = (sqx > THR) ? 3'sd3 : 3'sd1;
        lvy = (sqy > THR) ? 3'sd3 : 3'sd1;
        if (ox_reg[SAMPLE_BITS-1])
            lvx = -lvx;
        if (oy_reg[SAMPLE_BITS-1])
            lvy = -lvy;
    end

    // sample times conjugate decision, folded into the right half plane
    logic signed [PW-1:0] re, im;
    logic signed [W-1:0]  xv, yv;

    assign re = ox_reg * dx_reg + oy_reg * dy_reg;
    assign im = oy_reg * dx_reg - ox_reg * dy_reg;
    assign xv = {{(W-16-PW){re[PW-1]}}, re, 16'b0};
    assign yv = {{(W-16-PW){im[PW-1]}}, im, 16'b0};

    // phase error and loop filter
    logic signed [33:0]   zr;
    logic signed [15:0]   err;
    logic signed [48:0]   fsh;
    logic signed [31:0]   fin;
    logic signed [50:0]   inc, fsum;
    logic signed [47:0]   fi_sat;
    logic signed [48:0]   dsum;
    logic signed [47:0]   drive;
    logic [48:0]          mag_vs;
    logic [80:0]          full;
    logic [PHASE_BITS-1:0] q;

    assign zr  = cz_reg + 34'sd32768;
    assign err = zero_reg ? 16'sd0 : zr[31:16];
    assign fsh = ep_reg >>> 16;
    assign fin = (fsh[48:31] != {18{fsh[48]}}) ?
                 (fsh[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : fsh[31:0];

    assign inc  = {phi_reg[49], phi_reg} + {plo_reg[49], plo_reg >>> 16};
    assign fsum = {{3{fi_reg[47]}}, fi_reg} + inc;
    assign fi_sat = (fsum[50:47] != {4{fsum[50]}}) ?
                    (fsum[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : fsum[47:0];

    assign dsum  = {fin_reg[31], fin_reg, 16'b0} + {fi_reg[47], fi_reg};
    assign drive = (dsum[48] != dsum[47]) ?
                   (dsum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : dsum[47:0];

    assign mag_vs = vs_reg[48] ? 49'(-vs_reg) : vs_reg;
    assign full   = {17'b0, lo_reg} + {hi_reg, 32'b0};
    assign q      = full[SH +: PHASE_BITS];

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cx_reg <= flip ? -xin : xin;
            cy_reg <= flip ? -yin : yin;
            cz_reg <= r0;
        end
        else if (cmd.rot_step || cmd.vec_step)
        begin
            if (cw)
            begin
                cx_reg <= cx_reg + sx;
                cy_reg <= cy_reg - sy;
                cz_reg <= cz_reg + atn;
            end
            else
            begin
                cx_reg <= cx_reg - sx;
                cy_reg <= cy_reg + sy;
                cz_reg <= cz_reg - atn;
            end
        end
        else if (cmd.vec_init)
        begin
            if (re[PW-1] && !im[PW-1])
            begin
                cx_reg <= yv;
                cy_reg <= -xv;
                cz_reg <= QTR_TURN;
            end
            else if (re[PW-1])
            begin
                cx_reg <= -yv;
                cy_reg <= xv;
                cz_reg <= -QTR_TURN;
            end
            else
            begin
                cx_reg <= xv;
                cy_reg <= yv;
                cz_reg <= 34'sd0;
            end
        end

        if (cmd.round)
        begin
            ox_reg <= rsx;
            oy_reg <= rsy;
        end
        if (cmd.load_out)
        begin
            out_i_reg <= ox_reg;
            out_q_reg <= oy_reg;
        end
        if (cmd.decide)
        begin
            dx_reg <= lvx;
            dy_reg <= lvy;
        end
        if (cmd.vec_init)
            zero_reg <= (re == '0) && (im == '0);
        if (cmd.err_mul)
            ep_reg <= err * $signed({1'b0, loop_gain});
        if (cmd.fin)
        begin
            fin_reg <= fin;
            sum_reg <= {fin[31], fin} + {prev_err_reg[31], prev_err_reg};
        end
        if (cmd.int_mul)
        begin
            phi_reg <= sum_reg * $signed({1'b0, integ_coeff[31:16]});
            plo_reg <= sum_reg * $signed({1'b0, integ_coeff[15:0]});
        end
        if (cmd.drive)
            vs_reg <= {drive[47], drive} + {prev_drive_reg[47], prev_drive_reg};
        if (cmd.vco_mul)
        begin
            lo_reg  <= 64'(mag_vs[31:0]) * 64'(vco_coeff);
            hi_reg  <= 49'(mag_vs[48:32]) * 49'(vco_coeff);
            neg_reg <= vs_reg[48];
        end
    end

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg   <= '0;
            fi_reg         <= '0;
            prev_drive_reg <= '0;
            phase_reg      <= '0;
        end
        else
        begin
            if (cmd.fin)
                prev_err_reg <= fin;
            if (cmd.integ)
                fi_reg <= fi_sat;
            if (cmd.drive)
                prev_drive_reg <= drive;
            if (cmd.vco_add)
                phase_reg <= neg_reg ? phase_reg - q : phase_reg + q;
        end
    end

    assign out_i = out_i_reg;
    assign out_q = out_q_reg;

endmodule

FILE: rtl/qam16_decision_directed_pll_unit.sv
// top level of the decision-directed carrier phase pll for 16-qam
// depends on qddp_pkg, qddp_ctrl, qddp_datapath
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------
//  input    | in_valid, in_stall  | in_i, in_q
//  output   | out_valid, out_stall| out_i, out_q
//  config   | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// one sample is finished before the next is accepted: 16 rotation steps and
// 16 atan2 steps of the one shared cordic plus load, rounding, slicing, loop
// filter and vco, all in series through the phase loop
// the rotated sample is presented once rotation and rounding are done; a stalled
// output holds the sequencer in front of the next output write only
// reset clears the loop filter, vco phase and configuration to defaults
module qam16_decision_directed_pll_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [SAMPLE_BITS-1:0]           in_i,
    input  logic signed [SAMPLE_BITS-1:0]           in_q,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [SAMPLE_BITS-1:0]           out_i,
    output logic signed [SAMPLE_BITS-1:0]           out_q,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qddp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [31:0]                             cfg_data
);

    qddp_pkg::cmd_t cmd;

    // configuration registers
    logic [31:0] loop_gain_reg, integ_coeff_reg, vco_coeff_reg;
    logic        cfg_wr;

    // writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_gain_reg   <= 32'd65536;
            integ_coeff_reg <= 32'd0;
            vco_coeff_reg   <= 32'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                qddp_pkg::REG_LOOP_GAIN:   loop_gain_reg   <= cfg_data;
                qddp_pkg::REG_INTEG_COEFF: integ_coeff_reg <= cfg_data;
                qddp_pkg::REG_VCO_COEFF:   vco_coeff_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // sequencer: one command per cycle while working and not held by a stalled output, owns both handshakes
    qddp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and loop state
    qddp_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_i        (in_i),
        .in_q        (in_q),
        .loop_gain   (loop_gain_reg),
        .integ_coeff (integ_coeff_reg),
        .vco_coeff   (vco_coeff_reg),
        .out_i       (out_i),
        .out_q       (out_q)
    );

endmodule

FILE: rtl/qddp_checker.sv
// port-level assertions on the decision-directed pll, bound to the top level
// depends on qam16_decision_directed_pll_unit_defines.svh
`include "qam16_decision_directed_pll_unit_defines.svh"

module qddp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] out_i,
    input logic [SAMPLE_BITS-1:0] out_q,
    input logic                   cfg_ready
);

    // a stalled result holds
    `QDDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_i) && $stable(out_q))
    // one sample at a time: busy right after a transfer
    `QDDP_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
    // a result only appears while a sample is in work
    `QDDP_ASSERT_NOW(a_out_while_busy, $rose(out_valid), in_stall)
    // config always taken
    `QDDP_ASSERT_NOW(a_cfg_ready, in_valid || !in_valid, cfg_ready)

endmodule

bind qam16_decision_directed_pll_unit qddp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_qddp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q),
    .cfg_ready (cfg_ready)
);
